// File: src/pli_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pli_pkg: shared constants and types for the positional list store
// Holds the list capacity, element width, status codes and the control
// structures passed between the top level, the cell row and each cell.
// ----------------------------------------------------------------------------
package pli_pkg;

  // List sizing.
  localparam int CAPACITY      = 128;
  localparam int ELEMENT_WIDTH = 32;
  localparam int CNT_W         = 8;
  localparam int DATA_W        = 32;

  // Removed-value readout is an OR over groups of cells, one group register each.
  localparam int GROUP_SIZE = 8;
  localparam int NUM_GROUPS = (CAPACITY + GROUP_SIZE - 1) / GROUP_SIZE;

  typedef logic [ELEMENT_WIDTH-1:0] elem_t;
  typedef logic [CNT_W-1:0]         cnt_t;
  typedef logic [1:0]               status_t;

  // Status codes.
  localparam status_t ST_OK     = 2'd0;
  localparam status_t ST_BADPOS = 2'd1;
  localparam status_t ST_FULL   = 2'd2;

  // Operation codes of the action field.
  localparam logic ACT_INSERT = 1'b0;
  localparam logic ACT_DELETE = 1'b1;

  // Operation broadcast to the whole row of cells.
  typedef struct packed {
    logic  ins;   // valid insert this cycle
    logic  del;   // valid delete this cycle
    cnt_t  idx;   // 0-based target slot
  } op_t;

  // Per-cell decoded control.
  typedef struct packed {
    logic ins;
    logic del;
    logic at;      // this cell is the target slot
    logic beyond;  // this cell lies past the target slot
  } cell_ctl_t;

endpackage
`default_nettype wire

// File: src/pli_cell.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pli_cell: one slot of the list
// Holds one element. On an insert it loads the new value or takes its left
// neighbor's element; on a delete it takes its right neighbor's element.
// ----------------------------------------------------------------------------
module pli_cell (
  input  wire logic                 clk,
  input  wire pli_pkg::cell_ctl_t   ctl,
  input  wire pli_pkg::elem_t       val,
  input  wire pli_pkg::elem_t       left,
  input  wire pli_pkg::elem_t       right,
  output pli_pkg::elem_t            data,
  output pli_pkg::elem_t            sel_data
);

  // Element register: shift up on insert, shift down on delete.
  always_ff @(posedge clk) begin
    if (ctl.ins) begin
      if (ctl.at) begin
        data <= val;
      end else if (ctl.beyond) begin
        data <= left;
      end
    end else if (ctl.del && (ctl.at || ctl.beyond)) begin
      data <= right;
    end
  end

  // Present the element for readout only when it is the one being deleted.
  assign sel_data = (ctl.del && ctl.at) ? data : '0;

endmodule
`default_nettype wire

// File: src/pli_chain.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pli_chain: row of list cells with grouped readout
// Decodes the broadcast operation for every cell, links each cell to its
// neighbors and captures the deleted element in one register per group.
// ----------------------------------------------------------------------------
module pli_chain (
  input  wire logic              clk,
  input  wire pli_pkg::op_t      op,
  input  wire pli_pkg::elem_t    val,
  input  wire logic              capture,
  output pli_pkg::elem_t         group_q [pli_pkg::NUM_GROUPS]
);

  localparam int PAD = pli_pkg::NUM_GROUPS * pli_pkg::GROUP_SIZE;

  pli_pkg::elem_t    data    [pli_pkg::CAPACITY];
  pli_pkg::elem_t    sel_pad [PAD];
  pli_pkg::cell_ctl_t ctl    [pli_pkg::CAPACITY];

  genvar k, g;

  // One cell per slot, each linked to its neighbors.
  generate
    for (k = 0; k < pli_pkg::CAPACITY; k++) begin : g_cell
      localparam pli_pkg::cnt_t K = pli_pkg::cnt_t'(k);
      pli_pkg::elem_t left_d;
      pli_pkg::elem_t right_d;

      assign ctl[k].ins    = op.ins;
      assign ctl[k].del    = op.del;
      assign ctl[k].at     = (op.idx == K);
      assign ctl[k].beyond = (K > op.idx);

      if (k == 0) begin : g_first
        assign left_d = '0;
      end else begin : g_mid_l
        assign left_d = data[k-1];
      end

      if (k == pli_pkg::CAPACITY - 1) begin : g_last
        assign right_d = '0;
      end else begin : g_mid_r
        assign right_d = data[k+1];
      end

      pli_cell u_cell (
        .clk      (clk),
        .ctl      (ctl[k]),
        .val      (val),
        .left     (left_d),
        .right    (right_d),
        .data     (data[k]),
        .sel_data (sel_pad[k])
      );
    end

    // Pad the last group with zeros when capacity is not a multiple.
    for (k = pli_pkg::CAPACITY; k < PAD; k++) begin : g_pad
      assign sel_pad[k] = '0;
    end

    // Each group ORs its cells' readout into a register.
    for (g = 0; g < pli_pkg::NUM_GROUPS; g++) begin : g_group
      pli_pkg::elem_t acc;

      always_comb begin
        acc = '0;
        for (int j = 0; j < pli_pkg::GROUP_SIZE; j++) begin
          acc = acc | sel_pad[g * pli_pkg::GROUP_SIZE + j];
        end
      end

      always_ff @(posedge clk) begin
        if (capture) begin
          group_q[g] <= acc;
        end
      end
    end
  endgenerate

endmodule
`default_nettype wire

// File: src/positional_list_insert_delete.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// positional_list_insert_delete: fixed-capacity list with positional edits
// Insert and delete at 1-based positions over a row of shifting cells.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel (in_valid/in_ready) takes one item: action (0 insert,
//   1 delete), position and value. Every item yields exactly one result on
//   the output channel (out_valid/out_ready): status, removed_value, count.
//   Cells at and beyond the target shift in the cycle the item is accepted,
//   so the list itself is updated at once. The deleted element is gathered
//   through one group register stage and then an output register, which
//   raises out_valid. Throughput is one item per cycle while out_ready stays
//   high; items overlap in the two stages.
//   When the receiver stalls, the result holds in the output register, the
//   next item waits in the middle stage, and in_ready drops once both are
//   occupied.
//   Reset empties the list (count zero) and clears both stages; it needs no
//   sweep over the cells, since only slots below the count are ever read.
// ----------------------------------------------------------------------------
module positional_list_insert_delete (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         in_valid,
  output logic              in_ready,
  input  wire logic         action,
  input  wire logic [7:0]   position,
  input  wire logic [31:0]  value,
  output logic              out_valid,
  input  wire logic         out_ready,
  output logic [1:0]        status,
  output logic [31:0]       removed_value,
  output logic [7:0]        count
);

  pli_pkg::cnt_t    length;
  pli_pkg::cnt_t    length_next;
  pli_pkg::status_t st_next;
  pli_pkg::op_t     op;
  logic             accept;
  logic             advance;
  logic             s1_valid;
  pli_pkg::status_t s1_status;
  pli_pkg::cnt_t    s1_count;
  pli_pkg::elem_t   group_q [pli_pkg::NUM_GROUPS];
  pli_pkg::elem_t   removed_or;
  logic             ins_bad;
  logic             del_bad;
  logic             full;

  // Handshake: the middle stage moves on whenever the output is free.
  assign advance  = s1_valid && (!out_valid || out_ready);
  assign in_ready = !s1_valid || advance;
  assign accept   = in_valid && in_ready;

  // Position checks and the resulting length.
  assign ins_bad = (position == '0) ||
                   ({1'b0, position} > ({1'b0, length} + 9'd1));
  assign del_bad = (position == '0) || (position > length);
  assign full    = (length == pli_pkg::cnt_t'(pli_pkg::CAPACITY));

  always_comb begin
    op.ins      = 1'b0;
    op.del      = 1'b0;
    op.idx      = position - 8'd1;
    st_next     = pli_pkg::ST_OK;
    length_next = length;
    case (action)
      pli_pkg::ACT_INSERT: begin
        if (ins_bad) begin
          st_next = pli_pkg::ST_BADPOS;
        end else if (full) begin
          st_next = pli_pkg::ST_FULL;
        end else begin
          op.ins      = accept;
          length_next = length + 8'd1;
        end
      end
      pli_pkg::ACT_DELETE: begin
        if (del_bad) begin
          st_next = pli_pkg::ST_BADPOS;
        end else begin
          op.del      = accept;
          length_next = length - 8'd1;
        end
      end
      default: begin
        st_next = pli_pkg::ST_BADPOS;
      end
    endcase
  end

  // Row of cells holding the list.
  pli_chain u_chain (
    .clk     (clk),
    .op      (op),
    .val     (pli_pkg::elem_t'(value)),
    .capture (accept),
    .group_q (group_q)
  );

  // Final OR over the group registers.
  always_comb begin
    removed_or = '0;
    for (int g = 0; g < pli_pkg::NUM_GROUPS; g++) begin
      removed_or = removed_or | group_q[g];
    end
  end

  // List length.
  always_ff @(posedge clk) begin
    if (rst) begin
      length <= '0;
    end else if (accept) begin
      length <= length_next;
    end
  end

  // Middle stage: status and count wait here with the group registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_status <= st_next;
      s1_count  <= length_next;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      status        <= s1_status;
      removed_value <= pli_pkg::DATA_W'(removed_or);
      count         <= s1_count;
    end
  end

  // Checks on the list bookkeeping.
  a_len_bound: assert property (@(posedge clk) disable iff (rst)
    length <= pli_pkg::cnt_t'(pli_pkg::CAPACITY))
    else $error("list length exceeds capacity");

  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status != pli_pkg::ST_OK) |-> (removed_value == '0))
    else $error("failed item returned a nonzero removed value");

  a_ins_grow: assert property (@(posedge clk) disable iff (rst)
    (accept && op.ins) |=> (length == $past(length) + 8'd1))
    else $error("insert did not grow the list by one");

  a_del_shrink: assert property (@(posedge clk) disable iff (rst)
    (accept && op.del) |=> (length == $past(length) - 8'd1))
    else $error("delete did not shrink the list by one");

endmodule
`default_nettype wire

// File: bench/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for the positional list store
// Drives insert and delete items through the valid/ready input channel. A
// shadow copy of the list predicts every result, and the results are checked
// in order as they leave the output channel. Both sides idle and stall at
// random, and the receiver holds off long enough to stall the input.
// ----------------------------------------------------------------------------
module tb;

  localparam int LONG_HOLD_CYCLES = 200;
  localparam int DRAIN_LIMIT      = 5000;

  typedef struct {
    pli_pkg::status_t st;
    pli_pkg::elem_t   removed;
    pli_pkg::cnt_t    cnt;
  } list_result_t;

  logic        clk       = 1'b0;
  logic        rst       = 1'b1;
  logic        in_valid  = 1'b0;
  logic        action    = pli_pkg::ACT_INSERT;
  logic [7:0]  position  = '0;
  logic [31:0] value     = '0;
  logic        out_ready = 1'b0;
  logic        in_ready;
  logic        out_valid;
  logic [1:0]  status;
  logic [31:0] removed_value;
  logic [7:0]  count;

  // Shadow copy of the list contents and its length.
  pli_pkg::elem_t list_mem [pli_pkg::CAPACITY];
  int             list_len = 0;
  list_result_t   pending_results [$];

  int fail_count    = 0;
  int hold_requests = 0;
  bit tx_gaps_on    = 1'b0;
  bit rx_stalls_on  = 1'b0;
  bit growing       = 1'b1;

  positional_list_insert_delete dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .action        (action),
    .position      (position),
    .value         (value),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .status        (status),
    .removed_value (removed_value),
    .count         (count)
  );

  always #5 clk = ~clk;

  // Apply one operation to the shadow list and return the result it causes.
  function automatic list_result_t apply_list_op(logic act, pli_pkg::cnt_t pos,
                                                 pli_pkg::elem_t val);
    list_result_t res;
    int           p;
    int           k;
    p           = int'(pos);
    res.st      = pli_pkg::ST_OK;
    res.removed = '0;
    if (act == pli_pkg::ACT_INSERT) begin
      if (p < 1 || p > list_len + 1) begin
        res.st = pli_pkg::ST_BADPOS;
      end else if (list_len >= pli_pkg::CAPACITY) begin
        res.st = pli_pkg::ST_FULL;
      end else begin
        for (k = list_len; k > p - 1; k--) list_mem[k] = list_mem[k - 1];
        list_mem[p - 1] = val;
        list_len++;
      end
    end else begin
      if (p < 1 || p > list_len) begin
        res.st = pli_pkg::ST_BADPOS;
      end else begin
        res.removed = list_mem[p - 1];
        for (k = p; k < list_len; k++) list_mem[k - 1] = list_mem[k];
        list_len--;
      end
    end
    res.cnt = pli_pkg::cnt_t'(list_len);
    return res;
  endfunction

  // Random idle length: mostly from the shortest range, rarely from the longest.
  function automatic int random_idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 2);
    if (r < 95) return $urandom_range(3, 8);
    return $urandom_range(20, 60);
  endfunction

  function automatic void note_mismatch(string field, longint unsigned want,
                                        longint unsigned got);
    fail_count++;
    $error("%s: expected 0x%0h, actual 0x%0h", field, want, got);
  endfunction

  // Offer one item, hold it until accepted, then record its expected result.
  task automatic offer_item(logic act, pli_pkg::cnt_t pos, pli_pkg::elem_t val);
    int gap;
    gap = (tx_gaps_on && $urandom_range(0, 99) < 30) ? random_idle_len() : 0;
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    action   <= act;
    position <= pos;
    value    <= val;
    in_valid <= 1'b1;
    do @(posedge clk); while (!(in_valid && in_ready));
    pending_results.push_back(apply_list_op(act, pos, val));
  endtask

  // Stop offering items and wait for every outstanding result.
  task automatic pause_until_drained();
    int waited;
    waited = 0;
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_results.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (4) @(posedge clk);
  endtask

  // Random item whose length drifts between empty and full, mostly well formed.
  task automatic offer_random_item();
    logic act;
    int   r;
    int   p;
    if (list_len == pli_pkg::CAPACITY) growing = 1'b0;
    else if (list_len == 0) growing = 1'b1;
    else if ($urandom_range(0, 99) < 2) growing = !growing;
    act = (($urandom_range(0, 99) < 75) == growing) ? pli_pkg::ACT_INSERT
                                                    : pli_pkg::ACT_DELETE;
    r = $urandom_range(0, 99);
    if (r < 8) p = $urandom_range(0, 255);
    else if (act == pli_pkg::ACT_INSERT)
      p = (r < 14) ? list_len + 1 : $urandom_range(1, list_len + 1);
    else if (list_len == 0) p = $urandom_range(0, 255);
    else p = (r < 14) ? list_len : $urandom_range(1, list_len);
    offer_item(act, pli_pkg::cnt_t'(p), pli_pkg::elem_t'($urandom));
  endtask

  // Field extremes, both operations, and every bad-position case.
  task automatic test_directed();
    tx_gaps_on   = 1'b0;
    rx_stalls_on = 1'b0;
    offer_item(pli_pkg::ACT_DELETE, 8'd1, 32'h0000_0000);    // delete on an empty list
    offer_item(pli_pkg::ACT_DELETE, 8'd0, 32'hFFFF_FFFF);    // position zero
    offer_item(pli_pkg::ACT_INSERT, 8'd0, 32'h1234_5678);    // position zero
    offer_item(pli_pkg::ACT_INSERT, 8'd2, 32'h1234_5678);    // insert past end
    offer_item(pli_pkg::ACT_INSERT, 8'd1, 32'hFFFF_FFFF);
    offer_item(pli_pkg::ACT_INSERT, 8'd2, 32'h0000_0000);    // append
    offer_item(pli_pkg::ACT_INSERT, 8'd1, 32'hA5A5_A5A5);    // front
    offer_item(pli_pkg::ACT_INSERT, 8'd2, 32'h5A5A_5A5A);    // middle
    offer_item(pli_pkg::ACT_INSERT, 8'd6, 32'h0000_0001);    // insert past end
    offer_item(pli_pkg::ACT_INSERT, 8'd255, 32'hFFFF_FFFF);  // largest position
    offer_item(pli_pkg::ACT_DELETE, 8'd5, 32'h0000_0000);    // delete past end
    offer_item(pli_pkg::ACT_DELETE, 8'd255, 32'h0000_0000);
    offer_item(pli_pkg::ACT_DELETE, 8'd2, 32'hFFFF_FFFF);    // middle, value ignored
    offer_item(pli_pkg::ACT_DELETE, 8'd3, 32'h0000_0000);    // last
    offer_item(pli_pkg::ACT_DELETE, 8'd1, 32'h0000_0000);    // first
    offer_item(pli_pkg::ACT_DELETE, 8'd1, 32'h0000_0000);    // leaves the list empty
    offer_item(pli_pkg::ACT_DELETE, 8'd1, 32'h0000_0000);
    offer_item(pli_pkg::ACT_INSERT, 8'd1, 32'h8000_0001);
    offer_item(pli_pkg::ACT_DELETE, 8'd1, 32'h7FFF_FFFE);
    pause_until_drained();
  endtask

  // Fill to capacity, probe the full-list cases, then empty it again.
  task automatic test_full_list();
    int i;
    tx_gaps_on   = 1'b0;
    rx_stalls_on = 1'b1;
    for (i = 0; i < pli_pkg::CAPACITY; i++)
      offer_item(pli_pkg::ACT_INSERT, pli_pkg::cnt_t'($urandom_range(1, list_len + 1)),
                 pli_pkg::elem_t'($urandom));
    // Inserts refused as full, then positions that are bad even though the list is full.
    offer_item(pli_pkg::ACT_INSERT, 8'd1, 32'hDEAD_0001);
    offer_item(pli_pkg::ACT_INSERT, pli_pkg::cnt_t'(pli_pkg::CAPACITY + 1), 32'hDEAD_0002);
    offer_item(pli_pkg::ACT_INSERT, pli_pkg::cnt_t'(pli_pkg::CAPACITY + 2), 32'hDEAD_0003);
    offer_item(pli_pkg::ACT_INSERT, 8'd0, 32'hDEAD_0004);
    offer_item(pli_pkg::ACT_DELETE, pli_pkg::cnt_t'(pli_pkg::CAPACITY + 1), 32'h0000_0000);
    offer_item(pli_pkg::ACT_DELETE, pli_pkg::cnt_t'(pli_pkg::CAPACITY), 32'h0000_0000);
    offer_item(pli_pkg::ACT_INSERT, pli_pkg::cnt_t'(pli_pkg::CAPACITY), 32'hBEEF_0005);
    while (list_len > 0)
      offer_item(pli_pkg::ACT_DELETE, pli_pkg::cnt_t'($urandom_range(1, list_len)),
                 pli_pkg::elem_t'($urandom));
    pause_until_drained();
  endtask

  // Receiver holds off while the sender keeps offering items back to back.
  task automatic test_backpressure();
    tx_gaps_on   = 1'b0;
    rx_stalls_on = 1'b0;
    @(negedge clk);
    hold_requests++;
    repeat (30) offer_random_item();
    pause_until_drained();
  endtask

  task automatic test_random(int n, bit gaps, bit stalls);
    tx_gaps_on   = gaps;
    rx_stalls_on = stalls;
    repeat (n) offer_random_item();
    pause_until_drained();
  endtask

  // Receiver side: long hold-offs on request, else random stalls when enabled.
  initial begin : drive_out_ready
    int holds_served;
    int stall_left;
    holds_served = 0;
    stall_left   = 0;
    forever begin
      @(negedge clk);
      if (hold_requests != holds_served) begin
        out_ready <= 1'b0;
        repeat (LONG_HOLD_CYCLES - 1) @(negedge clk);
        holds_served++;
      end else if (!rx_stalls_on) begin
        out_ready <= 1'b1;
      end else if (stall_left > 0) begin
        out_ready <= 1'b0;
        stall_left--;
      end else if ($urandom_range(0, 99) < 70) begin
        out_ready <= 1'b1;
      end else begin
        out_ready  <= 1'b0;
        stall_left = random_idle_len() - 1;
      end
    end
  end

  // Compare each accepted result with the oldest expected one.
  always @(posedge clk) begin : check_results
    list_result_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        fail_count++;
        $error("result with none expected: status %0d count %0d", status, count);
      end else begin
        want = pending_results.pop_front();
        if (status !== want.st) note_mismatch("status", want.st, status);
        if (removed_value !== want.removed)
          note_mismatch("removed_value", want.removed, removed_value);
        if (count !== want.cnt) note_mismatch("count", want.cnt, count);
      end
    end
  end

  initial begin
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_directed();
    test_full_list();
    test_backpressure();
    test_random(200, 1'b0, 1'b0);
    test_random(200, 1'b1, 1'b0);
    test_random(200, 1'b0, 1'b1);
    test_random(200, 1'b1, 1'b1);
    if (pending_results.size() != 0) begin
      fail_count++;
      $error("%0d expected results never arrived", pending_results.size());
    end
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // Run limit, several times the slowest correct run.
  initial begin
    #10_000_000;
    $display("TEST FAILED");
    $finish;
  end

endmodule

// File: filelist.f
src/pli_pkg.sv
src/pli_cell.sv
src/pli_chain.sv
src/positional_list_insert_delete.sv
bench/tb.sv
